// ----- hw/rtl/u8dec_pkg.sv -----
// shared types and constants for the utf-8 to 16-bit unit decoder
package u8dec_pkg;

  // decoder phase
  typedef enum logic [1:0] {
    PH_IDLE    = 2'd0,
    PH_COLLECT = 2'd1,
    PH_HALTED  = 2'd2
  } phase_t;

  // lead byte classes, compared on the masked top bits
  localparam logic [4:0] LEAD4_TAG = 5'b11110;
  localparam logic [3:0] LEAD3_TAG = 4'b1110;
  localparam logic [2:0] LEAD2_TAG = 3'b110;

  localparam int UNIT_W = 16;

  // one decoded result beat
  typedef struct packed {
    logic [UNIT_W-1:0] code_unit;
    logic              unit_valid;
    logic              final_result;
    logic              halted_flag;
  } result_t;

endpackage

// ----- hw/rtl/u8dec_step.sv -----
// decoder state and the per-byte update logic
module u8dec_step (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  advance,
  input  logic [7:0]            data_byte,
  input  logic                  stream_end,
  output logic                  produce,
  output u8dec_pkg::result_t    result
);

  u8dec_pkg::phase_t                 phase, phase_next;
  logic [1:0]                        pending, pending_next;
  logic [u8dec_pkg::UNIT_W-1:0]      partial, partial_next;

  logic                              is_lead4, is_lead3, is_lead2;
  logic [u8dec_pkg::UNIT_W-1:0]      shifted;
  logic [1:0]                        pend_dec;

  assign is_lead4 = (data_byte[7:3] == u8dec_pkg::LEAD4_TAG);
  assign is_lead3 = (data_byte[7:4] == u8dec_pkg::LEAD3_TAG);
  assign is_lead2 = (data_byte[7:5] == u8dec_pkg::LEAD2_TAG);
  assign shifted  = {partial[u8dec_pkg::UNIT_W-7:0], data_byte[5:0]};
  assign pend_dec = pending - 2'd1;

  // next state
  always_comb begin
    phase_next   = u8dec_pkg::PH_IDLE;
    pending_next = 2'd0;
    partial_next = '0;
    unique case (phase)
      u8dec_pkg::PH_HALTED: begin
        if (!stream_end) begin
          phase_next = u8dec_pkg::PH_HALTED;
        end
      end
      u8dec_pkg::PH_COLLECT: begin
        if (pend_dec != 2'd0 && !stream_end) begin
          phase_next   = u8dec_pkg::PH_COLLECT;
          pending_next = pend_dec;
          partial_next = shifted;
        end
      end
      default: begin
        if (!stream_end) begin
          if (is_lead4) begin
            phase_next = u8dec_pkg::PH_HALTED;
          end else if (is_lead3) begin
            phase_next   = u8dec_pkg::PH_COLLECT;
            pending_next = 2'd2;
            partial_next = {12'd0, data_byte[3:0]};
          end else if (is_lead2) begin
            phase_next   = u8dec_pkg::PH_COLLECT;
            pending_next = 2'd1;
            partial_next = {11'd0, data_byte[4:0]};
          end
        end
      end
    endcase
  end

  // result for this byte
  always_comb begin
    produce             = 1'b0;
    result.code_unit    = '0;
    result.unit_valid   = 1'b0;
    result.final_result = stream_end;
    result.halted_flag  = 1'b0;
    unique case (phase)
      u8dec_pkg::PH_HALTED: begin
        produce            = stream_end;
        result.halted_flag = 1'b1;
      end
      u8dec_pkg::PH_COLLECT: begin
        if (pend_dec == 2'd0) begin
          produce           = 1'b1;
          result.code_unit  = shifted;
          result.unit_valid = 1'b1;
        end else begin
          // cut off by the end of the stream
          produce           = stream_end;
          result.unit_valid = 1'b1;
        end
      end
      default: begin
        if (is_lead4) begin
          produce            = stream_end;
          result.halted_flag = 1'b1;
        end else if (is_lead3 || is_lead2) begin
          produce           = stream_end;
          result.unit_valid = 1'b1;
        end else begin
          // ascii or stray byte passes through raw
          produce           = 1'b1;
          result.code_unit  = {8'd0, data_byte};
          result.unit_valid = 1'b1;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase   <= u8dec_pkg::PH_IDLE;
      pending <= 2'd0;
      partial <= '0;
    end else if (advance) begin
      phase   <= phase_next;
      pending <= pending_next;
      partial <= partial_next;
    end
  end

endmodule

// ----- hw/rtl/u8dec_out.sv -----
// result register on the output side
module u8dec_out (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  load,
  input  u8dec_pkg::result_t    load_data,
  input  logic                  take,
  output logic                  full,
  output u8dec_pkg::result_t    data
);

  logic full_next;

  always_comb begin
    priority if (load) begin
      full_next = 1'b1;
    end else if (take) begin
      full_next = 1'b0;
    end else begin
      full_next = full;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else begin
      full <= full_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data <= load_data;
    end
  end

endmodule

// ----- hw/rtl/utf8_to_utf16_decoder_core.sv -----
// top level of the streaming utf-8 to 16-bit code unit decoder
//
//  channel   direction  beat contents
//  s_axis    in         one utf-8 byte, tlast on the last byte of the stream
//  m_axis    out        one 16-bit code unit with flags, tlast on the end result
//
//  one byte per cycle unless a held result stalls it; each byte goes from
//  input beat to result beat via the input register, then the result register
//  the input register feeds the decoder state update, which runs in the same
//  cycle as the byte leaves the input register
//  rst is synchronous and clears the decoder to idle and empties both registers
//  when m_tready is low the result register holds; bytes that give no result
//  still drain, and s_tready drops only when a held byte needs the full slot
module utf8_to_utf16_decoder_core (
  input  logic        clk,
  input  logic        rst,
  // s_axis
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] data_byte
  input  logic        s_tlast,   // stream_end
  // m_axis
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [15:0] code_unit
  output logic        m_tlast,   // final_result
  output logic [1:0]  m_tuser    // [0] unit_valid, [1] halted_flag
);

  // input register
  logic       in_full;
  logic [7:0] in_byte;
  logic       in_end;

  // step logic and result register
  logic                  produce;
  u8dec_pkg::result_t    step_result;
  u8dec_pkg::result_t    out_data;
  logic                  out_full;
  logic                  out_take;
  logic                  advance;
  logic                  s_fire;

  assign out_take = out_full && m_tready;
  // the byte moves on if it gives no result or the result slot will be free
  assign advance  = in_full && (!produce || !out_full || m_tready);
  assign s_tready = !in_full || advance;
  assign s_fire   = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (s_fire) begin
      in_full <= 1'b1;
    end else if (advance) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_fire) begin
      in_byte <= s_tdata;
      in_end  <= s_tlast;
    end
  end

  u8dec_step u_step (
    .clk        (clk),
    .rst        (rst),
    .advance    (advance),
    .data_byte  (in_byte),
    .stream_end (in_end),
    .produce    (produce),
    .result     (step_result)
  );

  u8dec_out u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (advance && produce),
    .load_data (step_result),
    .take      (out_take),
    .full      (out_full),
    .data      (out_data)
  );

  assign m_tvalid   = out_full;
  assign m_tdata    = out_data.code_unit;
  assign m_tlast    = out_data.final_result;
  assign m_tuser[0] = out_data.unit_valid;
  assign m_tuser[1] = out_data.halted_flag;

endmodule
